// ===== rtl/ssmd_pkg.sv =====
`default_nettype none
package ssmd_pkg;

   // store geometry and requester ports
   localparam int unsigned SAVE_DEPTH = 524288;
   localparam int unsigned PORT_COUNT = 2;
   localparam int unsigned STORE_AW   = $clog2(SAVE_DEPTH);
   localparam int unsigned PORT_W     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

   localparam int unsigned SIZE_W   = 24;
   localparam int unsigned CSR_IDX_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SAVE_BYTES = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IR_PRESENT = 8'd1;

   localparam logic [SIZE_W-1:0] SAVE_BYTES_RST = 24'h080000;
   localparam logic [SIZE_W-1:0] EEP_SMALL_LIMIT = 24'h000200;

   // command codes
   localparam logic [7:0] CMD_READ     = 8'h03;
   localparam logic [7:0] CMD_READ_HI  = 8'h0B;
   localparam logic [7:0] CMD_WRITE    = 8'h02;
   localparam logic [7:0] CMD_WRITE_HI = 8'h0A;
   localparam logic [7:0] CMD_IR       = 8'h08;
   localparam logic [7:0] IR_REPLY     = 8'hAA;
   localparam logic [7:0] FILL_BYTE    = 8'hFF;

   typedef logic [PORT_W-1:0]   port_idx_type;
   typedef logic [STORE_AW-1:0] store_idx_type;

   typedef enum logic [2:0] {
      LAY_NONE,
      LAY_EEP_SMALL,
      LAY_EEP_2ADDR,
      LAY_EEP_3ADDR,
      LAY_FLASH,
      LAY_UNKNOWN
   } layout_type;

   typedef enum logic [1:0] {
      RPL_KEEP,
      RPL_SET,
      RPL_MEM
   } reply_kind_type;

   typedef enum logic {
      BK_EXEC,
      BK_FINISH
   } back_state_type;

   // classified item handed from front to back
   typedef struct packed {
      port_idx_type      port;
      logic [7:0]        tx;
      logic              hold;
      layout_type        layout;
      logic              ir;
      logic [SIZE_W-1:0] limit;
   } item_type;

   // one store access per cycle
   typedef struct packed {
      logic          wr;
      logic          rd;
      store_idx_type idx;
      logic [7:0]    data;
   } store_req_type;

   function automatic layout_type classify(input logic [SIZE_W-1:0] sz);
      layout_type lay;
      unique case (sz) inside
         24'h000000:                         lay = LAY_NONE;
         24'h000200:                         lay = LAY_EEP_SMALL;
         24'h002000, 24'h008000, 24'h010000: lay = LAY_EEP_2ADDR;
         24'h020000:                         lay = LAY_EEP_3ADDR;
         24'h040000, 24'h080000, 24'h100000, 24'h800000: lay = LAY_FLASH;
         default:                            lay = LAY_UNKNOWN;
      endcase
      return lay;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/spi_save_memory_device.sv =====
// Path: an item accepted on req_ is queued, then popped and executed (store
//   access), then its reply is registered onto rsp_ in the finish step.
// Flow: the back end executes one item, then posts its reply before taking the next;
//   a two-entry queue lets req_ take items back to back until full while results wait.
// Reset: synchronous, active high; the store is then swept to 0xFF, one byte a
//   cycle, over all SAVE_DEPTH (524288) bytes with req_tready low; csr_ always open.
`default_nettype none
module spi_save_memory_device (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // item channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] tx_byte
   input  wire logic                           req_tuser,   // [0] port_sel
   input  wire logic                           req_tlast,   // deselect after byte (hold_select = 0)
   // result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] rx_byte
   output logic                                rsp_tuser,   // [0] save_dirty
   // register writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ssmd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ssmd_pkg::SIZE_W-1:0]    csr_data
);

   logic                    q_valid;
   logic                    q_pop;
   ssmd_pkg::item_type      q_item;
   ssmd_pkg::store_req_type st_req;
   logic [7:0]              st_rd_data;
   logic                    st_busy;

   // front: config registers, layout decode, item queue
   ssmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .hold_off   (st_busy),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // back: per-port sessions and reply register
   ssmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .st_req     (st_req),
      .st_rd_data (st_rd_data),
      .st_busy    (st_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // save array with post-reset fill sweep
   ssmd_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (st_req),
      .rd_data (st_rd_data),
      .busy    (st_busy)
   );

endmodule
`default_nettype wire

// ===== rtl/ssmd_store.sv =====
`default_nettype none
module ssmd_store (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ssmd_pkg::store_req_type req,
   output logic [7:0]                 rd_data,
   output logic                       busy
);

   ssmd_pkg::store_idx_type clr_idx_ff, clr_idx_in;
   logic                    clr_busy_ff, clr_busy_in;
   logic [7:0]              mem [ssmd_pkg::SAVE_DEPTH];
   logic [7:0]              rd_data_ff;
   ssmd_pkg::store_idx_type wr_idx;
   logic [7:0]              wr_val;
   logic                    wr_en;

   // fill sweep after reset writes the erased value everywhere
   always_comb begin
      clr_idx_in  = clr_idx_ff + ssmd_pkg::store_idx_type'(1);
      clr_busy_in = clr_busy_ff &&
                    (clr_idx_ff != ssmd_pkg::store_idx_type'(ssmd_pkg::SAVE_DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_idx_ff  <= clr_idx_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   assign wr_en  = clr_busy_ff || req.wr;
   assign wr_idx = clr_busy_ff ? clr_idx_ff : req.idx;
   assign wr_val = clr_busy_ff ? ssmd_pkg::FILL_BYTE : req.data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_val;
      end
      if (req.rd) begin
         rd_data_ff <= mem[req.idx];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule
`default_nettype wire

// ===== rtl/ssmd_front.sv =====
`default_nettype none
module ssmd_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic                              req_tlast,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ssmd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ssmd_pkg::SIZE_W-1:0]       csr_data,
   input  wire logic                              hold_off,
   output logic                                   q_valid,
   output ssmd_pkg::item_type                     q_item,
   input  wire logic                              q_pop
);

   logic [ssmd_pkg::SIZE_W-1:0] save_bytes_ff, save_bytes_in;
   logic                        ir_ff, ir_in;
   ssmd_pkg::item_type          q_mem_ff [2];
   logic                        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                  count_ff, count_in;
   logic                        push;
   ssmd_pkg::item_type          new_item;
   ssmd_pkg::layout_type        lay;

   assign csr_ready = 1'b1;

   always_comb begin
      save_bytes_in = save_bytes_ff;
      ir_in         = ir_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ssmd_pkg::REG_SAVE_BYTES: save_bytes_in = csr_data;
            ssmd_pkg::REG_IR_PRESENT: ir_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         save_bytes_ff <= ssmd_pkg::SAVE_BYTES_RST;
         ir_ff         <= 1'b0;
      end else begin
         save_bytes_ff <= save_bytes_in;
         ir_ff         <= ir_in;
      end
   end

   // classify by chip layout at accept time; user must keep config static while busy (not enforced)
   always_comb begin
      lay             = ssmd_pkg::classify(save_bytes_ff);
      new_item.port   = (ssmd_pkg::PORT_COUNT == 1) ? '0 :
                        ssmd_pkg::port_idx_type'(req_tuser);
      new_item.tx     = req_tdata;
      new_item.hold   = !req_tlast;
      new_item.layout = lay;
      new_item.ir     = ir_ff;
      new_item.limit  = (lay == ssmd_pkg::LAY_EEP_SMALL) ? ssmd_pkg::EEP_SMALL_LIMIT
                                                         : save_bytes_ff;
   end

   // two-entry item queue
   assign req_tready = (count_ff != 2'd2) && !hold_off;
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = q_mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !req_tready)
      else $error("queue full but still ready");

   assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count overflow");

endmodule
`default_nettype wire

// ===== rtl/ssmd_back.sv =====
`default_nettype none
module ssmd_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire ssmd_pkg::item_type       q_item,
   output logic                          q_pop,
   output ssmd_pkg::store_req_type       st_req,
   input  wire logic [7:0]               st_rd_data,
   input  wire logic                     st_busy,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,
   output logic                          rsp_tuser
);

   ssmd_pkg::back_state_type state_ff, state_in;

   logic [2:0]  cnt_ff   [ssmd_pkg::PORT_COUNT];
   logic [7:0]  cmd_ff   [ssmd_pkg::PORT_COUNT];
   logic [31:0] addr_ff  [ssmd_pkg::PORT_COUNT];
   logic [7:0]  reply_ff [ssmd_pkg::PORT_COUNT];
   logic        dirty_ff;

   ssmd_pkg::port_idx_type   pend_port_ff;
   ssmd_pkg::reply_kind_type pend_kind_ff, pend_kind_in;
   logic [7:0]               pend_val_ff, pend_val_in;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   logic        rsp_dirty_ff;

   ssmd_pkg::port_idx_type p;
   logic [2:0]  cnt, cnt_in, last, lane;
   logic [7:0]  cmd, cmd_in;
   logic [31:0] addr, addr_in;
   logic        advance, data_phase, is_wr, addr_phase, in_range, hi_page;
   logic        out_free, finish;
   logic [7:0]  final_reply;

   // sequencer: one item executes, then its reply is posted
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssmd_pkg::BK_EXEC:   if (q_valid && !st_busy) state_in = ssmd_pkg::BK_FINISH;
         ssmd_pkg::BK_FINISH: if (out_free) state_in = ssmd_pkg::BK_EXEC;
         default:             state_in = ssmd_pkg::BK_EXEC;
      endcase
   end

   always_comb begin
      q_pop  = (state_ff == ssmd_pkg::BK_EXEC) && q_valid && !st_busy;
      finish = (state_ff == ssmd_pkg::BK_FINISH) && out_free;
   end

   // session decode for the head item
   always_comb begin
      p    = q_item.port;
      cnt  = cnt_ff[p];
      cmd  = cmd_ff[p];
      addr = addr_ff[p];

      cnt_in       = cnt;
      cmd_in       = cmd;
      addr_in      = addr;
      pend_kind_in = ssmd_pkg::RPL_KEEP;
      pend_val_in  = 8'h00;
      advance      = 1'b1;
      data_phase   = 1'b0;
      addr_phase   = 1'b0;
      is_wr        = 1'b0;
      last         = 3'd4;
      hi_page      = (cmd == ssmd_pkg::CMD_WRITE_HI) || (cmd == ssmd_pkg::CMD_READ_HI);

      if (q_item.layout == ssmd_pkg::LAY_NONE) begin
         advance = 1'b0;
      end else if (cnt == 3'd0) begin
         if (q_item.tx == 8'h00) begin
            advance = 1'b0;
         end else begin
            cmd_in       = q_item.tx;
            addr_in      = 32'h0;
            pend_kind_in = ssmd_pkg::RPL_SET;
         end
      end else begin
         unique case (q_item.layout)
            ssmd_pkg::LAY_EEP_SMALL: begin
               if ((cmd == ssmd_pkg::CMD_READ) || (cmd == ssmd_pkg::CMD_READ_HI) ||
                   (cmd == ssmd_pkg::CMD_WRITE) || (cmd == ssmd_pkg::CMD_WRITE_HI)) begin
                  if (cnt < 3'd2) begin
                     addr_in      = 32'({hi_page, q_item.tx});
                     pend_kind_in = ssmd_pkg::RPL_SET;
                  end else begin
                     data_phase = 1'b1;
                     is_wr      = (cmd == ssmd_pkg::CMD_WRITE) ||
                                  (cmd == ssmd_pkg::CMD_WRITE_HI);
                  end
               end else begin
                  pend_kind_in = ssmd_pkg::RPL_SET;
               end
            end
            ssmd_pkg::LAY_EEP_2ADDR, ssmd_pkg::LAY_EEP_3ADDR: begin
               if ((cmd == ssmd_pkg::CMD_READ) || (cmd == ssmd_pkg::CMD_WRITE)) begin
                  last  = (q_item.layout == ssmd_pkg::LAY_EEP_3ADDR) ? 3'd4 : 3'd3;
                  is_wr = (cmd == ssmd_pkg::CMD_WRITE);
                  if (cnt < last) begin
                     addr_phase = 1'b1;
                  end else begin
                     data_phase = 1'b1;
                  end
               end else begin
                  pend_kind_in = ssmd_pkg::RPL_SET;
               end
            end
            ssmd_pkg::LAY_FLASH: begin
               if ((cmd == ssmd_pkg::CMD_READ) || (cmd == ssmd_pkg::CMD_WRITE_HI)) begin
                  is_wr = (cmd == ssmd_pkg::CMD_WRITE_HI);
                  if (cnt < last) begin
                     addr_phase = 1'b1;
                  end else begin
                     data_phase = 1'b1;
                  end
               end else if (cmd == ssmd_pkg::CMD_IR) begin
                  pend_kind_in = ssmd_pkg::RPL_SET;
                  pend_val_in  = q_item.ir ? ssmd_pkg::IR_REPLY : 8'h00;
               end else begin
                  pend_kind_in = ssmd_pkg::RPL_SET;
               end
            end
            default: ;  // unknown size: only the count moves
         endcase
      end

      // address bytes arrive high first
      lane = last - 3'd1 - cnt;
      if (addr_phase) begin
         addr_in      = addr | (32'(q_item.tx) << {lane[1:0], 3'b000});
         pend_kind_in = ssmd_pkg::RPL_SET;
      end

      in_range = (addr < 32'(q_item.limit)) && (addr < 32'(ssmd_pkg::SAVE_DEPTH));
      if (data_phase) begin
         addr_in = addr + 32'd1;
         if (is_wr || !in_range) begin
            pend_kind_in = ssmd_pkg::RPL_SET;
         end else begin
            pend_kind_in = ssmd_pkg::RPL_MEM;
         end
      end

      if (advance) begin
         if (q_item.hold) begin
            cnt_in = (cnt < 3'd4) ? cnt + 3'd1 : cnt;
         end else begin
            cnt_in = 3'd0;
         end
      end

      st_req.wr   = q_pop && data_phase && is_wr && in_range;
      st_req.rd   = q_pop && data_phase && !is_wr && in_range;
      st_req.idx  = addr[ssmd_pkg::STORE_AW-1:0];
      st_req.data = q_item.tx;
   end

   always_comb begin
      case (pend_kind_ff)
         ssmd_pkg::RPL_MEM: final_reply = st_rd_data;
         ssmd_pkg::RPL_SET: final_reply = pend_val_ff;
         default:           final_reply = reply_ff[pend_port_ff];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssmd_pkg::BK_EXEC;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_kind_ff <= ssmd_pkg::RPL_KEEP;
         for (int i = 0; i < int'(ssmd_pkg::PORT_COUNT); i++) begin
            cnt_ff[i]   <= 3'd0;
            cmd_ff[i]   <= 8'h00;
            addr_ff[i]  <= 32'h0;
            reply_ff[i] <= 8'h00;
         end
      end else begin
         state_ff <= state_in;
         if (q_pop) begin
            cnt_ff[p]    <= cnt_in;
            cmd_ff[p]    <= cmd_in;
            addr_ff[p]   <= addr_in;
            pend_kind_ff <= pend_kind_in;
            if (st_req.wr) begin
               dirty_ff <= 1'b1;
            end
         end
         if (finish) begin
            reply_ff[pend_port_ff] <= final_reply;
            rsp_valid_ff           <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         pend_port_ff <= p;
         pend_val_ff  <= pend_val_in;
      end
      if (finish) begin
         rsp_data_ff  <= final_reply;
         rsp_dirty_ff <= dirty_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_dirty_ff;

   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ssmd_pkg::BK_FINISH))
      else $error("item popped without finish step");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ssmd_pkg::BK_FINISH))
      else $error("reply posted outside finish step");

   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $past(dirty_ff)) |-> dirty_ff)
      else $error("dirty flag cleared");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] <= 3'd4) && !(st_req.wr && st_req.rd))
      else $error("count past saturation or store access conflict");

endmodule
`default_nettype wire
